/* src/xrg_pkg.sv */
// Shared types, constants and the generator step function for the xorshift128 range generator.
// No dependencies; every other file in src imports this package.
package xrg_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 6;
  localparam int unsigned DivCntW  = 5;

  // Number of generator steps run after a new seed.
  localparam logic [CountW-1:0] WARMUP_STEPS = 6'd40;

  // Last step index of the bit-serial remainder unit.
  localparam logic [DivCntW-1:0] DIV_LAST = 5'd31;

  // Generator state after reset.
  localparam logic [WordW-1:0] INIT_A = 32'd123456789;
  localparam logic [WordW-1:0] INIT_B = 32'd362436069;
  localparam logic [WordW-1:0] INIT_C = 32'd521288629;
  localparam logic [WordW-1:0] INIT_D = 32'd88675123;

  // Operation codes on the func field.
  localparam logic [1:0] FUNC_SEED  = 2'd0;
  localparam logic [1:0] FUNC_RAW   = 2'd1;
  localparam logic [1:0] FUNC_RANGE = 2'd2;

  // Four state words of the generator.
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } gen_state_t;

  // One job handed from the front to the back through the queue.
  typedef struct packed {
    logic             is_range;
    logic [WordW-1:0] word;
    logic [WordW-1:0] low;
    logic [WordW-1:0] span;
  } job_t;

  // One xorshift128 step; the new word is the d member of the result.
  function automatic gen_state_t xs_advance(input gen_state_t s);
    logic [WordW-1:0] t;
    gen_state_t       r;
    t   = s.a ^ (s.a << 11);
    r.a = s.b;
    r.b = s.c;
    r.c = s.d;
    r.d = s.d ^ (s.d >> 19) ^ t ^ (t >> 8);
    return r;
  endfunction

endpackage

/* src/xrg_in_if.sv */
// Request channel of the xorshift128 range generator: valid/ready plus the item fields.
// Depends on xrg_pkg for the word width.
interface xrg_in_if import xrg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [WordW-1:0]        seed_value;
  logic signed [WordW-1:0] range_low;
  logic signed [WordW-1:0] range_high;

  modport source (output valid, func, seed_value, range_low, range_high, input ready);
  modport sink   (input valid, func, seed_value, range_low, range_high, output ready);
endinterface

/* src/xrg_out_if.sv */
// Result channel of the xorshift128 range generator: valid/ready plus the result fields.
// Depends on xrg_pkg for the word width.
interface xrg_out_if import xrg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] result_word;
  logic             span_error;

  modport source (output valid, result_word, span_error, input ready);
  modport sink   (input valid, result_word, span_error, output ready);
endinterface

/* src/xorshift128_range_generator_top.sv */
// Top level of the xorshift128 range generator: front end, job queue and back end.
// Depends on xrg_pkg, xrg_in_if, xrg_out_if, xrg_front, xrg_queue and xrg_back.
//
// Usage:
//   req carries one item per valid/ready handshake: func selects seed (0), raw word (1)
//   or integer range (2); func 3 is accepted and ignored. rsp returns one result for
//   each raw or range item, in order, as result_word and span_error.
//   A raw item's result becomes valid once the back end has taken its job from the
//   queue and loaded the result register; it is taken when the receiver is ready.
//   A range item with a nonzero span passes through the 32-step restoring remainder
//   unit in the back end before its result is valid; a zero span returns range_low
//   with span_error set straight from the back end's load state. The back end works
//   on one job at a time and takes the next only after the previous result is taken,
//   passing through its load, remainder and output states.
//   A seed item replaces the fourth state word and then steps the generator 40 times,
//   during which req.ready stays low; it produces no result.
//   A two-entry queue sits between the front and back end, so the front keeps taking
//   items while the back end works or the receiver stalls; rsp holds its result
//   stable until taken, and req.ready drops once the queue is full.
//   rst (synchronous, active high) restores the standard xorshift128 seed words and
//   empties the queue and drops any result held in the result register.
module xorshift128_range_generator_top import xrg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  xrg_in_if.sink    req,
  xrg_out_if.source rsp
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // Item intake and generator.
  xrg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Decoupling queue.
  xrg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Range reduction and result register.
  xrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .rsp       (rsp)
  );

endmodule

/* src/xrg_front.sv */
// Front end: accepts items, holds the generator state, runs seed warm-up and queues jobs.
// Depends on xrg_pkg and xrg_in_if.
module xrg_front import xrg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  xrg_in_if.sink    req,
  output logic      push_valid,
  input  logic      push_ready,
  output job_t      push_job
);

  typedef enum logic [1:0] {
    F_RUN  = 2'b01,
    F_WARM = 2'b10
  } front_state_t;

  front_state_t      fstate;
  gen_state_t        gen;
  gen_state_t        gen_step;
  logic [CountW-1:0] warmup_count;
  logic              accept;
  logic              is_job;

  // Next generator state, taken on each raw or range item and each warm-up step.
  assign gen_step = xs_advance(gen);

  // Items are taken only outside warm-up and with room in the queue.
  assign req.ready = (fstate == F_RUN) && push_ready;
  assign accept    = req.valid && req.ready;
  assign is_job    = (req.func == FUNC_RAW) || (req.func == FUNC_RANGE);

  // Raw and range items become a job carrying the fresh word and the span.
  assign push_valid        = accept && is_job;
  assign push_job.is_range = (req.func == FUNC_RANGE);
  assign push_job.word     = gen_step.d;
  assign push_job.low      = $unsigned(req.range_low);
  assign push_job.span     = $unsigned(req.range_high) - $unsigned(req.range_low);

  // Generator state and warm-up sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate       <= F_RUN;
      gen.a        <= INIT_A;
      gen.b        <= INIT_B;
      gen.c        <= INIT_C;
      gen.d        <= INIT_D;
      warmup_count <= '0;
    end else begin
      case (fstate)
        F_RUN: begin
          if (accept) begin
            if (req.func == FUNC_SEED) begin
              gen.d        <= req.seed_value;
              warmup_count <= '0;
              if (WARMUP_STEPS != '0) begin
                fstate <= F_WARM;
              end
            end else if (is_job) begin
              gen <= gen_step;
            end
          end
        end
        F_WARM: begin
          gen <= gen_step;
          if (warmup_count == WARMUP_STEPS - 1'b1) begin
            warmup_count <= '0;
            fstate       <= F_RUN;
          end else begin
            warmup_count <= warmup_count + 1'b1;
          end
        end
        default: begin
          fstate <= F_RUN;
        end
      endcase
    end
  end

endmodule

/* src/xrg_queue.sv */
// Two-entry job queue between the front end and the back end.
// Depends on xrg_pkg for the job type.
module xrg_queue import xrg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       head;
  job_t       tail;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = head;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // The head always holds the oldest job; the tail moves up on a pop.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= tail;
      end else if (push) begin
        head <= push_job;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_job;
      end else begin
        tail <= push_job;
      end
    end
  end

endmodule

/* src/xrg_back.sv */
// Back end: takes jobs from the queue, reduces range words bit-serially, holds the result.
// Depends on xrg_pkg and xrg_out_if.
module xrg_back import xrg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  job_t      pop_job,
  xrg_out_if.source rsp
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } back_state_t;

  back_state_t        bstate;
  logic [DivCntW-1:0] div_count;
  logic [WordW-1:0]   dividend;
  logic [WordW-1:0]   rem;
  logic [WordW-1:0]   span;
  logic [WordW-1:0]   low;
  logic [WordW-1:0]   res_word;
  logic               res_err;
  logic [WordW:0]     trial;
  logic               fits;
  logic [WordW-1:0]   rem_next;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  assign trial    = {rem, dividend[WordW-1]};
  assign fits     = (trial >= {1'b0, span});
  assign rem_next = fits ? WordW'(trial - {1'b0, span}) : trial[WordW-1:0];

  assign pop_ready       = (bstate == B_IDLE);
  assign rsp.valid       = (bstate == B_OUT);
  assign rsp.result_word = res_word;
  assign rsp.span_error  = res_err;

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      div_count <= '0;
    end else begin
      case (bstate)
        B_IDLE: begin
          if (pop_valid) begin
            if (pop_job.is_range && (pop_job.span != '0)) begin
              bstate    <= B_DIV;
              div_count <= '0;
            end else begin
              bstate <= B_OUT;
            end
          end
        end
        B_DIV: begin
          div_count <= div_count + 1'b1;
          if (div_count == DIV_LAST) begin
            bstate <= B_OUT;
          end
        end
        B_OUT: begin
          if (rsp.ready) begin
            bstate <= B_IDLE;
          end
        end
        default: begin
          bstate <= B_IDLE;
        end
      endcase
    end
  end

  // Datapath: operand load, remainder steps and the result register.
  always_ff @(posedge clk) begin
    case (bstate)
      B_IDLE: begin
        dividend <= pop_job.word;
        rem      <= '0;
        span     <= pop_job.span;
        low      <= pop_job.low;
        if (!pop_job.is_range) begin
          res_word <= pop_job.word;
          res_err  <= 1'b0;
        end else begin
          res_word <= pop_job.low;
          res_err  <= (pop_job.span == '0);
        end
      end
      B_DIV: begin
        rem      <= rem_next;
        dividend <= dividend << 1;
        if (div_count == DIV_LAST) begin
          res_word <= rem_next + low;
          res_err  <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // The partial remainder always stays below a nonzero span.
  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (bstate == B_DIV) |-> ((rem < span) && (span != '0)))
    else $error("partial remainder not below span");

  // A result waiting on a stalled receiver holds its value.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    ((bstate == B_OUT) && !rsp.ready) |=>
      ((bstate == B_OUT) && $stable(res_word) && $stable(res_err)))
    else $error("stalled result changed");

  // A job taken from the queue always leaves the idle state.
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (bstate != B_IDLE))
    else $error("popped job was dropped");

  // A range job with zero span is reported with span_error set and range_low as its result.
  a_err_source: assert property (@(posedge clk) disable iff (rst)
    ((bstate == B_IDLE) && pop_valid && pop_job.is_range && (pop_job.span == '0))
      |=> ((bstate == B_OUT) && res_err && (res_word == $past(pop_job.low))))
    else $error("zero span not reported");

endmodule
